FILE: rtl/utc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, constants and the code point to Windows-1251 mapping function
// for the UTF-8 to CP1251 decoder.
// ----------------------------------------------------------------------------
package utc_pkg;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned PtrW     = $clog2(ResDepth);
  localparam int unsigned CntW     = $clog2(ResDepth + 1);

  typedef enum logic [1:0] {
    ST_CHAR = 2'd0,
    ST_TERM = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       end_mark;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  typedef struct packed {
    logic            space_ok;
    logic [CntW-1:0] level;
  } fifo_stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] cp;
  } map_res_t;

  function automatic map_res_t rom_lookup(input logic [15:0] uc);
    map_res_t r;
    r.hit = 1'b1;
    r.cp  = 8'h00;
    case (uc)
      16'h201A: r.cp = 8'h82;
      16'h0453: r.cp = 8'h83;
      16'h201E: r.cp = 8'h84;
      16'h2026: r.cp = 8'h85;
      16'h2020: r.cp = 8'h86;
      16'h2021: r.cp = 8'h87;
      16'h20AC: r.cp = 8'h88;
      16'h2030: r.cp = 8'h89;
      16'h0409: r.cp = 8'h8A;
      16'h2039: r.cp = 8'h8B;
      16'h040A: r.cp = 8'h8C;
      16'h040C: r.cp = 8'h8D;
      16'h040B: r.cp = 8'h8E;
      16'h040F: r.cp = 8'h8F;
      16'h0452: r.cp = 8'h90;
      16'h2018: r.cp = 8'h91;
      16'h2019: r.cp = 8'h92;
      16'h201C: r.cp = 8'h93;
      16'h201D: r.cp = 8'h94;
      16'h2022: r.cp = 8'h95;
      16'h2013: r.cp = 8'h96;
      16'h2014: r.cp = 8'h97;
      16'h2122: r.cp = 8'h99;
      16'h0459: r.cp = 8'h9A;
      16'h203A: r.cp = 8'h9B;
      16'h045A: r.cp = 8'h9C;
      16'h045C: r.cp = 8'h9D;
      16'h045B: r.cp = 8'h9E;
      16'h045F: r.cp = 8'h9F;
      16'h00A0: r.cp = 8'hA0;
      16'h040E: r.cp = 8'hA1;
      16'h045E: r.cp = 8'hA2;
      16'h0408: r.cp = 8'hA3;
      16'h00A4: r.cp = 8'hA4;
      16'h0490: r.cp = 8'hA5;
      16'h00A6: r.cp = 8'hA6;
      16'h00A7: r.cp = 8'hA7;
      16'h0401: r.cp = 8'hA8;
      16'h00A9: r.cp = 8'hA9;
      16'h0404: r.cp = 8'hAA;
      16'h00AB: r.cp = 8'hAB;
      16'h00AC: r.cp = 8'hAC;
      16'h00AD: r.cp = 8'hAD;
      16'h00AE: r.cp = 8'hAE;
      16'h0407: r.cp = 8'hAF;
      16'h00B0: r.cp = 8'hB0;
      16'h00B1: r.cp = 8'hB1;
      16'h0406: r.cp = 8'hB2;
      16'h0456: r.cp = 8'hB3;
      16'h0491: r.cp = 8'hB4;
      16'h00B5: r.cp = 8'hB5;
      16'h00B6: r.cp = 8'hB6;
      16'h00B7: r.cp = 8'hB7;
      16'h0451: r.cp = 8'hB8;
      16'h2116: r.cp = 8'hB9;
      16'h0454: r.cp = 8'hBA;
      16'h00BB: r.cp = 8'hBB;
      16'h0458: r.cp = 8'hBC;
      16'h0405: r.cp = 8'hBD;
      16'h0455: r.cp = 8'hBE;
      16'h0457: r.cp = 8'hBF;
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // 11-bit code point from a two-byte sequence
  function automatic map_res_t map_code(input logic [10:0] code);
    map_res_t   r;
    logic [10:0] diff;
    r.hit = 1'b1;
    r.cp  = 8'h00;
    diff  = 11'h000;
    if (code >= 11'h410 && code <= 11'h44F) begin
      diff = code - 11'h350;
      r.cp = diff[7:0];
    end else if (code >= 11'h080 && code <= 11'h0FF) begin
      r.cp = code[7:0];
    end else if (code >= 11'h402 && code <= 11'h403) begin
      diff = code - 11'h382;
      r.cp = diff[7:0];
    end else begin
      r = rom_lookup({5'b0, code});
    end
    return r;
  endfunction

endpackage

FILE: rtl/utc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_in_if
// Request channel carrying one UTF-8 byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface utc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

FILE: rtl/utc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_out_if
// Result channel carrying one Windows-1251 byte with status and end mark.
// ----------------------------------------------------------------------------
interface utc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       end_mark;

  modport source (output valid, output out_byte, output status, output end_mark,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input end_mark,
                  output ready);
endinterface

FILE: rtl/utc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_decode
// Stream state (held lead byte, halt flag) and per-byte result generation.
// Produces zero, one or two results for each request taken.
// ----------------------------------------------------------------------------
module utc_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  input  logic              fin_i,
  output utc_pkg::dec_out_t dec_o
);
  import utc_pkg::*;

  logic       lead_q, lead_d;
  logic [4:0] bits_q, bits_d;
  logic       halt_q, halt_d;
  map_res_t   map;

  assign map = map_code({bits_q, byte_i[5:0]});

  always_comb begin
    lead_d = lead_q;
    bits_d = bits_q;
    halt_d = halt_q;
    dec_o  = '0;
    dec_o.r0.status = ST_CHAR;
    dec_o.r1.status = ST_TERM;
    dec_o.r1.end_mark = 1'b1;
    if (take_i) begin
      if (halt_q) begin
        if (fin_i) begin
          halt_d = 1'b0;
          lead_d = 1'b0;
          bits_d = 5'd0;
        end
      end else if (lead_q) begin
        lead_d = 1'b0;
        bits_d = 5'd0;
        dec_o.n = 2'd1;
        if (map.hit) begin
          dec_o.r0.out_byte = map.cp;
          if (fin_i) dec_o.n = 2'd2;
        end else begin
          dec_o.r0.status   = ST_ERR;
          dec_o.r0.end_mark = 1'b1;
          if (!fin_i) halt_d = 1'b1;
        end
      end else if (byte_i == 8'h00) begin
        dec_o.n = 2'd1;
        dec_o.r0.status   = ST_TERM;
        dec_o.r0.end_mark = 1'b1;
        if (!fin_i) halt_d = 1'b1;
      end else if (!byte_i[7]) begin
        dec_o.n = fin_i ? 2'd2 : 2'd1;
        dec_o.r0.out_byte = byte_i;
      end else if (!byte_i[5]) begin
        if (fin_i) begin
          dec_o.n = 2'd1;
          dec_o.r0.status   = ST_ERR;
          dec_o.r0.end_mark = 1'b1;
        end else begin
          lead_d = 1'b1;
          bits_d = byte_i[4:0];
        end
      end else begin
        dec_o.n = 2'd1;
        dec_o.r0.status   = ST_ERR;
        dec_o.r0.end_mark = 1'b1;
        if (!fin_i) halt_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 1'b0;
      bits_q <= 5'd0;
      halt_q <= 1'b0;
    end else begin
      lead_q <= lead_d;
      bits_q <= bits_d;
      halt_q <= halt_d;
    end
  end

endmodule

FILE: rtl/utc_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_res_fifo
// Result queue: takes up to two results per cycle, delivers one per cycle while popped.
// ----------------------------------------------------------------------------
module utc_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utc_pkg::dec_out_t   wr_i,
  input  logic                pop_i,
  output logic                valid_o,
  output utc_pkg::res_t       head_o,
  output utc_pkg::fifo_stat_t stat_o
);
  import utc_pkg::*;

  res_t            mem_q [ResDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  assign stat_o.space_ok = (cnt_q <= CntW'(ResDepth - 2));
  assign stat_o.level    = cnt_q;

  always_comb begin
    wptr_d = PtrW'(wptr_q + PtrW'(wr_i.n));
    rptr_d = pop ? PtrW'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = CntW'(cnt_q + CntW'(wr_i.n) - CntW'(pop));
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.n != 2'd0) mem_q[wptr_q] <= wr_i.r0;
    if (wr_i.n == 2'd2) mem_q[PtrW'(wptr_q + 1'b1)] <= wr_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: rtl/utf8_to_cp1251_decoder_core.sv
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, then decoded into
//   the result queue; it waits while the queue holds three or more results.
// Throughput: one byte per cycle while the result queue has room; the
//   single-result output port sends a character plus terminator one by one.
// Reset: asynchronous, active low; clears the held lead byte, the halt flag
//   and the result queue. No clearing pass.
// ----------------------------------------------------------------------------
// utf8_to_cp1251_decoder_core
// UTF-8 byte stream to Windows-1251 converter: input register, decode stage
// with stream state, four-entry result queue.
// ----------------------------------------------------------------------------
module utf8_to_cp1251_decoder_core (
  input  logic clk_i,
  input  logic rst_ni,
  utc_in_if.sink    in_i,
  utc_out_if.source out_o
);
  import utc_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       fin_q, fin_d;
  logic       load;
  logic       take;
  dec_out_t   dec;
  res_t       head;
  fifo_stat_t fstat;
  logic       fvalid;

  assign take     = vld_q && fstat.space_ok;
  assign in_i.ready = !vld_q || fstat.space_ok;
  assign load     = in_i.valid && in_i.ready;

  always_comb begin
    vld_d  = load ? 1'b1 : (take ? 1'b0 : vld_q);
    byte_d = load ? in_i.in_byte : byte_q;
    fin_d  = load ? in_i.is_final : fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    fin_q  <= fin_d;
  end

  utc_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (byte_q),
    .fin_i  (fin_q),
    .dec_o  (dec)
  );

  utc_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dec),
    .pop_i   (out_o.ready),
    .valid_o (fvalid),
    .head_o  (head),
    .stat_o  (fstat)
  );

  assign out_o.valid    = fvalid;
  assign out_o.out_byte = head.out_byte;
  assign out_o.status   = head.status;
  assign out_o.end_mark = head.end_mark;

  a_pair_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec.n == 2'd2) |-> (dec.r0.status == ST_CHAR && dec.r1.status == ST_TERM
                         && dec.r1.end_mark))
    else $error("two-result request not char followed by terminator");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> (dec.n == 2'd0))
    else $error("result produced without a request in the decode stage");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.level <= CntW'(ResDepth))
    else $error("result queue overflow");

  a_end_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fvalid && head.status != ST_CHAR) |-> head.end_mark)
    else $error("terminator or error result without end mark");

endmodule

FILE: verif/utf8_to_cp1251_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_cp1251_decoder_core_test
// Self-checking testbench for the UTF-8 to Windows-1251 decoder. Bytes are
// sent through the request channel with random gaps while the result channel
// stalls at random. Each accepted request updates a local decoder model, and
// its expected results are queued and compared field by field with the
// results in order. Directed cases cover the mapping ranges, the table,
// terminators, errors and halted strings. Random well-formed strings are
// mixed with noise.
// ----------------------------------------------------------------------------
module utf8_to_cp1251_decoder_core_test;
  import utc_pkg::*;

  localparam int unsigned ItemsTotal = 1150;
  localparam int unsigned WdogLimit  = 1000;
  localparam int unsigned PauseEvery = 300;

  // {cp1251 byte, code point}
  localparam logic [23:0] CP1251_ROM [61] = '{
    24'h82201A, 24'h830453, 24'h84201E, 24'h852026, 24'h862020,
    24'h872021, 24'h8820AC, 24'h892030, 24'h8A0409, 24'h8B2039,
    24'h8C040A, 24'h8D040C, 24'h8E040B, 24'h8F040F, 24'h900452,
    24'h912018, 24'h922019, 24'h93201C, 24'h94201D, 24'h952022,
    24'h962013, 24'h972014, 24'h992122, 24'h9A0459, 24'h9B203A,
    24'h9C045A, 24'h9D045C, 24'h9E045B, 24'h9F045F, 24'hA000A0,
    24'hA1040E, 24'hA2045E, 24'hA30408, 24'hA400A4, 24'hA50490,
    24'hA600A6, 24'hA700A7, 24'hA80401, 24'hA900A9, 24'hAA0404,
    24'hAB00AB, 24'hAC00AC, 24'hAD00AD, 24'hAE00AE, 24'hAF0407,
    24'hB000B0, 24'hB100B1, 24'hB20406, 24'hB30456, 24'hB40491,
    24'hB500B5, 24'hB600B6, 24'hB700B7, 24'hB80451, 24'hB92116,
    24'hBA0454, 24'hBB00BB, 24'hBC0458, 24'hBD0405, 24'hBE0455,
    24'hBF0457
  };

  logic clk;
  logic rst_ni;

  utc_in_if  in_ch ();
  utc_out_if out_ch ();

  utf8_to_cp1251_decoder_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // decoder model state
  logic       conv_lead_held;
  logic [4:0] conv_lead_bits;
  logic       conv_halted;

  res_t        cp1251_results_q [$];
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          gaps_on;
  bit          stalls_on;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic cp1251_lookup(input logic [10:0] code, output logic [7:0] cp);
    logic [10:0] d;
    cp = 8'h00;
    if (code >= 11'h410 && code <= 11'h44F) begin
      d  = code - 11'h350;
      cp = d[7:0];
      return 1'b1;
    end
    if (code >= 11'h080 && code <= 11'h0FF) begin
      cp = code[7:0];
      return 1'b1;
    end
    if (code >= 11'h402 && code <= 11'h403) begin
      d  = code - 11'h382;
      cp = d[7:0];
      return 1'b1;
    end
    for (int k = 0; k < 61; k++) begin
      if (CP1251_ROM[k][15:0] == {5'b0, code}) begin
        cp = CP1251_ROM[k][23:16];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_result(input logic [7:0] b, input status_e st);
    res_t r;
    r.out_byte = b;
    r.status   = st;
    r.end_mark = (st != ST_CHAR);
    cp1251_results_q.push_back(r);
  endfunction

  function automatic void predict_cp1251(input logic [7:0] b, input logic fin);
    logic [10:0] code;
    logic [7:0]  cp;
    if (conv_halted) begin
      if (fin) begin
        conv_halted    = 1'b0;
        conv_lead_held = 1'b0;
        conv_lead_bits = 5'd0;
      end
    end else if (conv_lead_held) begin
      code           = {conv_lead_bits, b[5:0]};
      conv_lead_held = 1'b0;
      conv_lead_bits = 5'd0;
      if (cp1251_lookup(code, cp)) begin
        push_result(cp, ST_CHAR);
        if (fin) push_result(8'h00, ST_TERM);
      end else begin
        push_result(8'h00, ST_ERR);
        if (!fin) conv_halted = 1'b1;
      end
    end else if (b == 8'h00) begin
      push_result(8'h00, ST_TERM);
      if (!fin) conv_halted = 1'b1;
    end else if (!b[7]) begin
      push_result(b, ST_CHAR);
      if (fin) push_result(8'h00, ST_TERM);
    end else if (!b[5]) begin
      if (fin) begin
        push_result(8'h00, ST_ERR);
      end else begin
        conv_lead_held = 1'b1;
        conv_lead_bits = b[4:0];
      end
    end else begin
      push_result(8'h00, ST_ERR);
      if (!fin) conv_halted = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // one request; returns in the time step of its acceptance with valid still high
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.is_final <= fin;
    do @(posedge clk); while (!in_ch.ready);
    predict_cp1251(b, fin);
    items_sent++;
  endtask

  task automatic send_pair(input logic [10:0] code, input logic fin);
    send_byte({3'b110, code[10:6]}, 1'b0);
    send_byte({2'b10, code[5:0]}, fin);
  endtask

  task automatic wait_results_drained();
    while (cp1251_results_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!stalls_on || $urandom_range(0, 99) < 65) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (cp1251_results_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.out_byte, 0);
      end else begin
        want = cp1251_results_q.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.end_mark !== want.end_mark)
          report_mismatch("end_mark", out_ch.end_mark, want.end_mark);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WdogLimit) begin
        $display("%0t: watchdog expired", $realtime);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_directed();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_pair(11'h410, 1'b0);       // first Cyrillic capital
    send_pair(11'h44F, 1'b0);       // last Cyrillic small
    send_pair(11'h080, 1'b0);
    send_pair(11'h0FF, 1'b0);
    send_pair(11'h402, 1'b0);
    send_pair(11'h403, 1'b0);
    send_pair(11'h491, 1'b0);       // table entry
    send_byte(8'hD0, 1'b0);         // continuation with 11xxxxxx, not checked
    send_byte(8'hD0, 1'b0);
    send_byte(8'h82, 1'b0);         // stray continuation taken as lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hC2, 1'b0);         // zero byte as continuation
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);         // final plain byte: char and terminator
    send_pair(11'h430, 1'b1);       // final mapped pair
    send_pair(11'h7FF, 1'b1);       // final unmapped pair: error only
    send_byte(8'hD0, 1'b1);         // string ends after a lead
    send_pair(11'h000, 1'b0);       // overlong: error and halt
    send_byte(8'h41, 1'b0);         // ignored
    send_byte(8'hFF, 1'b1);         // ignored, clears halt
    send_byte(8'hE0, 1'b0);         // three-byte lead: error and halt
    send_byte(8'h00, 1'b1);         // ignored, clears halt
    send_byte(8'h00, 1'b0);         // terminator and halt
    send_byte(8'h55, 1'b1);         // ignored, clears halt
    send_byte(8'h00, 1'b1);         // final zero: terminator, no halt
    send_byte(8'hFF, 1'b1);         // final byte 0xFF: error, no halt
  endtask

  task automatic send_wellformed_string();
    logic [7:0]  bytes_q [$];
    logic [10:0] code;
    int unsigned n;
    int unsigned ending;
    int unsigned idx;
    n      = $urandom_range(1, 10);
    ending = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          bytes_q.push_back(8'($urandom_range(1, 127)));
          continue;
        end
        1: code = 11'($urandom_range(11'h410, 11'h44F));
        2: code = 11'($urandom_range(11'h080, 11'h0FF));
        3: code = 11'h402 + 11'($urandom_range(0, 1));
        default: begin
          do idx = $urandom_range(0, 60); while (CP1251_ROM[idx][15:11] != 5'd0);
          code = CP1251_ROM[idx][10:0];
        end
      endcase
      bytes_q.push_back({3'b110, code[10:6]});
      bytes_q.push_back({2'b10, code[5:0]});
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], (ending == 0) && (i == bytes_q.size() - 1));
    case (ending)
      1: send_byte(8'h00, 1'b1);
      2: begin
        send_byte(8'h00, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) send_byte(8'($urandom), ($urandom_range(0, 5) == 0));
    if ($urandom_range(0, 1) != 0) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_streams();
    int unsigned next_pause;
    next_pause = items_sent + PauseEvery;
    while (items_sent < ItemsTotal) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 8) send_wellformed_string();
      else send_noise();
      if (items_sent >= next_pause) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_results_drained();
        next_pause = items_sent + PauseEvery;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.is_final  = 1'b0;
    out_ch.ready    = 1'b0;
    conv_lead_held  = 1'b0;
    conv_lead_bits  = 5'd0;
    conv_halted     = 1'b0;
    err_cnt         = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    gaps_on         = 1'b0;
    stalls_on       = 1'b0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_streams();

    in_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: utf8_to_cp1251_decoder_core.f
rtl/utc_pkg.sv
rtl/utc_in_if.sv
rtl/utc_out_if.sv
rtl/utc_decode.sv
rtl/utc_res_fifo.sv
rtl/utf8_to_cp1251_decoder_core.sv
verif/utf8_to_cp1251_decoder_core_test.sv
